>>> hdl/etgn_pkg.sv
// ----------------------------------------------------------------------------
// etgn_pkg
// Shared types, codes and sizes for the equation to gate netlist block.
// ----------------------------------------------------------------------------
`default_nettype none

package etgn_pkg;

   // sizes
   localparam int OP_STACK_DEPTH   = 16;
   localparam int EVAL_STACK_DEPTH = 32;
   localparam int MAX_GATES        = 1024;
   localparam int MAX_SIGNALS      = 64;
   localparam int QUEUE_DEPTH      = 4;

   localparam int OP_DEPTH_W   = $clog2(OP_STACK_DEPTH + 1);
   localparam int EVAL_DEPTH_W = $clog2(EVAL_STACK_DEPTH + 1);
   localparam int GATE_CNT_W   = $clog2(MAX_GATES + 1);
   localparam int GATE_ID_W    = 10;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // item kinds
   localparam logic [2:0] KIND_OPERAND = 3'd0;
   localparam logic [2:0] KIND_OPERATOR = 3'd1;
   localparam logic [2:0] KIND_LPAREN  = 3'd2;
   localparam logic [2:0] KIND_RPAREN  = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   // operator codes, paren mark on the operator stack
   localparam logic [1:0] OPC_AND   = 2'd0;
   localparam logic [1:0] OPC_XOR   = 2'd1;
   localparam logic [1:0] OPC_OR    = 2'd2;
   localparam logic [1:0] OPC_PAREN = 2'd3;

   // record codes
   localparam logic [1:0] REC_GATE  = 2'd0;
   localparam logic [1:0] REC_PIN   = 2'd1;
   localparam logic [1:0] REC_DRIVE = 2'd2;
   localparam logic [1:0] REC_ERROR = 2'd3;

   // error codes
   localparam logic [2:0] ERR_BAD_OPERAND = 3'd0;
   localparam logic [2:0] ERR_TOO_FEW     = 3'd1;
   localparam logic [2:0] ERR_UNMATCHED   = 3'd2;
   localparam logic [2:0] ERR_OPEN_PAREN  = 3'd3;
   localparam logic [2:0] ERR_COUNT       = 3'd4;
   localparam logic [2:0] ERR_IS_INPUT    = 3'd5;
   localparam logic [2:0] ERR_BAD_TARGET  = 3'd6;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd7;

   // configuration register indexes
   localparam logic CSR_INPUT_COUNT  = 1'b0;
   localparam logic CSR_OUTPUT_COUNT = 1'b1;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_DRIVE,
      TAIL_ERROR
   } tail_type;

   typedef enum logic [1:0] {
      STEP_GATE,
      STEP_PIN_A,
      STEP_PIN_B,
      STEP_TAIL
   } step_type;

   typedef struct packed {
      logic                 is_gate;
      logic [GATE_ID_W-1:0] id;
   } operand_type;

   // one classified item: an optional gate with two pins, then an optional tail record
   typedef struct packed {
      logic                 gate_en;
      logic [GATE_ID_W-1:0] gate_id;
      logic [1:0]           gate_kind;
      operand_type          pin_a;
      operand_type          pin_b;
      tail_type             tail;
      logic [GATE_ID_W-1:0] drive_gate;
      logic [5:0]           output_id;
      logic [2:0]           error_code;
   } command_type;

   typedef struct packed {
      logic        valid;
      command_type cmd;
   } queue_head_type;

endpackage

`default_nettype wire

>>> hdl/etgn_front.sv
// ----------------------------------------------------------------------------
// etgn_front
// Accepts tokens, runs the operator and operand stacks, classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module etgn_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic [6:0]           csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_kind,
   input  wire logic                 req_notation,
   input  wire logic [5:0]           req_operand_id,
   input  wire logic [1:0]           req_op_code,
   input  wire logic [5:0]           req_target_id,
   input  wire logic                 queue_full,
   output logic                      push_valid,
   output etgn_pkg::command_type     push_cmd
);

   localparam int OPD = etgn_pkg::OP_STACK_DEPTH;
   localparam int EVD = etgn_pkg::EVAL_STACK_DEPTH;

   logic [6:0] in_count_ff, out_count_ff;

   logic [1:0]                        oper_ff [OPD];
   logic [etgn_pkg::OP_DEPTH_W-1:0]   oper_depth_ff, oper_depth_in;
   logic [etgn_pkg::OP_DEPTH_W-1:0]   paren_cnt_ff, paren_cnt_in;
   etgn_pkg::operand_type             opnd_ff [EVD];
   logic [etgn_pkg::EVAL_DEPTH_W-1:0] opnd_depth_ff, opnd_depth_in;
   logic [etgn_pkg::GATE_CNT_W-1:0]   next_gate_ff, next_gate_in;
   logic                              discard_ff, discard_in;

   logic       accept;
   logic [1:0] opc;
   logic       fault, drive, mk_req, end_chk, clear;
   logic [2:0] fcode;
   logic [1:0] mk_op;
   logic       mk_ok;
   logic       opnd_push, opnd_merge;
   logic       oper_push, oper_pop1, oper_pop2, oper_set;
   logic [1:0] oper_val;
   logic [etgn_pkg::EVAL_DEPTH_W-1:0] od_after;
   etgn_pkg::operand_type             gate_ref, s0_after;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign opc       = (req_op_code == etgn_pkg::OPC_PAREN) ? etgn_pkg::OPC_OR : req_op_code;
   assign mk_ok     = (opnd_depth_ff >= etgn_pkg::EVAL_DEPTH_W'(2)) &&
                      (next_gate_ff < etgn_pkg::GATE_CNT_W'(etgn_pkg::MAX_GATES));
   assign gate_ref  = '{is_gate: 1'b1, id: next_gate_ff[etgn_pkg::GATE_ID_W-1:0]};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == etgn_pkg::CSR_INPUT_COUNT) in_count_ff <= csr_wdata;
         else out_count_ff <= csr_wdata;
      end
   end

   // classify the item and plan the stack moves
   always_comb begin
      fault      = 1'b0;
      fcode      = etgn_pkg::ERR_BAD_OPERAND;
      drive      = 1'b0;
      mk_req     = 1'b0;
      mk_op      = opc;
      end_chk    = 1'b0;
      clear      = 1'b0;
      opnd_push  = 1'b0;
      opnd_merge = 1'b0;
      oper_push  = 1'b0;
      oper_pop1  = 1'b0;
      oper_pop2  = 1'b0;
      oper_set   = 1'b0;
      oper_val   = opc;
      paren_cnt_in = paren_cnt_ff;
      discard_in   = discard_ff;
      od_after     = opnd_depth_ff;
      s0_after     = opnd_ff[0];
      if (discard_ff) begin
         if (req_kind == etgn_pkg::KIND_END) begin
            clear      = 1'b1;
            discard_in = 1'b0;
         end
      end else begin
         case (req_kind)
            etgn_pkg::KIND_OPERAND: begin
               if (!({1'b0, req_operand_id} < in_count_ff &&
                     7'(req_operand_id) < 7'(etgn_pkg::MAX_SIGNALS))) begin
                  fault = 1'b1;
               end else if (opnd_depth_ff >= etgn_pkg::EVAL_DEPTH_W'(EVD)) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_OVERFLOW;
               end else begin
                  opnd_push = 1'b1;
               end
            end
            etgn_pkg::KIND_OPERATOR: begin
               if (req_notation) begin
                  mk_req = 1'b1;
               end else if (oper_depth_ff != '0 && oper_ff[0] != etgn_pkg::OPC_PAREN) begin
                  mk_req   = 1'b1;
                  mk_op    = oper_ff[0];
                  oper_set = 1'b1;
               end else if (oper_depth_ff >= etgn_pkg::OP_DEPTH_W'(OPD)) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_OVERFLOW;
               end else begin
                  oper_push = 1'b1;
               end
            end
            etgn_pkg::KIND_LPAREN: begin
               if (req_notation) begin
                  fault = 1'b1;
               end else if (oper_depth_ff >= etgn_pkg::OP_DEPTH_W'(OPD)) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_OVERFLOW;
               end else begin
                  oper_push    = 1'b1;
                  oper_val     = etgn_pkg::OPC_PAREN;
                  paren_cnt_in = paren_cnt_ff + 1'b1;
               end
            end
            etgn_pkg::KIND_RPAREN: begin
               if (req_notation) begin
                  fault = 1'b1;
               end else if (oper_depth_ff == '0) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_UNMATCHED;
               end else if (oper_ff[0] == etgn_pkg::OPC_PAREN) begin
                  oper_pop1    = 1'b1;
                  paren_cnt_in = paren_cnt_ff - 1'b1;
               end else if (oper_depth_ff >= etgn_pkg::OP_DEPTH_W'(2) &&
                            oper_ff[1] == etgn_pkg::OPC_PAREN) begin
                  oper_pop2    = 1'b1;
                  paren_cnt_in = paren_cnt_ff - 1'b1;
                  mk_req       = 1'b1;
                  mk_op        = oper_ff[0];
               end else begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_UNMATCHED;
               end
            end
            etgn_pkg::KIND_END: begin
               clear = 1'b1;
               if ({1'b0, req_target_id} >= out_count_ff) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_BAD_TARGET;
               end else if (paren_cnt_ff != '0) begin
                  fault = 1'b1;
                  fcode = etgn_pkg::ERR_OPEN_PAREN;
               end else begin
                  end_chk = 1'b1;
                  if (oper_depth_ff != '0) begin
                     mk_req = 1'b1;
                     mk_op  = oper_ff[0];
                  end
               end
            end
            default: begin
            end
         endcase

         // apply the pending operator
         if (mk_req) begin
            if (!mk_ok) begin
               fault = 1'b1;
               fcode = (opnd_depth_ff < etgn_pkg::EVAL_DEPTH_W'(2)) ?
                       etgn_pkg::ERR_TOO_FEW : etgn_pkg::ERR_OVERFLOW;
            end else begin
               opnd_merge = 1'b1;
               od_after   = opnd_depth_ff - 1'b1;
               s0_after   = gate_ref;
            end
         end

         // check the result at end of equation
         if (end_chk && !fault) begin
            if (od_after != etgn_pkg::EVAL_DEPTH_W'(1)) begin
               fault = 1'b1;
               fcode = etgn_pkg::ERR_COUNT;
            end else if (!s0_after.is_gate) begin
               fault = 1'b1;
               fcode = etgn_pkg::ERR_IS_INPUT;
            end else begin
               drive = 1'b1;
            end
         end

         if (fault) begin
            clear      = 1'b1;
            discard_in = (req_kind != etgn_pkg::KIND_END);
         end
      end

      // drop the paren count with the stacks
      if (clear) paren_cnt_in = '0;
   end

   // next depths and gate counter
   always_comb begin
      oper_depth_in = oper_depth_ff;
      opnd_depth_in = opnd_depth_ff;
      next_gate_in  = next_gate_ff;
      if (oper_push) oper_depth_in = oper_depth_ff + 1'b1;
      if (oper_pop1) oper_depth_in = oper_depth_ff - 1'b1;
      if (oper_pop2) oper_depth_in = oper_depth_ff - etgn_pkg::OP_DEPTH_W'(2);
      if (opnd_push) opnd_depth_in = opnd_depth_ff + 1'b1;
      if (opnd_merge) begin
         opnd_depth_in = od_after;
         next_gate_in  = next_gate_ff + 1'b1;
      end
      if (clear) begin
         oper_depth_in = '0;
         opnd_depth_in = '0;
      end
   end

   // command for the back end
   always_comb begin
      push_cmd            = '0;
      push_cmd.gate_en    = opnd_merge;
      push_cmd.gate_id    = next_gate_ff[etgn_pkg::GATE_ID_W-1:0];
      push_cmd.gate_kind  = mk_op;
      push_cmd.pin_a      = opnd_ff[0];
      push_cmd.pin_b      = opnd_ff[1];
      push_cmd.tail       = fault ? etgn_pkg::TAIL_ERROR :
                            (drive ? etgn_pkg::TAIL_DRIVE : etgn_pkg::TAIL_NONE);
      push_cmd.drive_gate = s0_after.id;
      push_cmd.output_id  = req_target_id;
      push_cmd.error_code = fcode;
      push_valid          = accept && (opnd_merge || fault || drive);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         oper_depth_ff <= '0;
         opnd_depth_ff <= '0;
         paren_cnt_ff  <= '0;
         next_gate_ff  <= '0;
         discard_ff    <= 1'b0;
      end else if (accept) begin
         oper_depth_ff <= oper_depth_in;
         opnd_depth_ff <= opnd_depth_in;
         paren_cnt_ff  <= paren_cnt_in;
         next_gate_ff  <= next_gate_in;
         discard_ff    <= discard_in;
      end
   end

   // operator stack, top at entry 0
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < OPD; k++) begin
            if (oper_push) oper_ff[k] <= (k == 0) ? oper_val : oper_ff[(k == 0) ? 0 : k - 1];
            else if (oper_pop1 && k + 1 < OPD) oper_ff[k] <= oper_ff[(k + 1 < OPD) ? k + 1 : k];
            else if (oper_pop2 && k + 2 < OPD) oper_ff[k] <= oper_ff[(k + 2 < OPD) ? k + 2 : k];
            else if (oper_set && k == 0) oper_ff[k] <= opc;
         end
      end
   end

   // operand stack, top at entry 0
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < EVD; k++) begin
            if (opnd_push) begin
               opnd_ff[k] <= (k == 0) ?
                  '{is_gate: 1'b0, id: etgn_pkg::GATE_ID_W'(req_operand_id)} :
                  opnd_ff[(k == 0) ? 0 : k - 1];
            end else if (opnd_merge) begin
               if (k == 0) opnd_ff[k] <= gate_ref;
               else if (k + 1 < EVD) opnd_ff[k] <= opnd_ff[(k + 1 < EVD) ? k + 1 : k];
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/etgn_queue.sv
// ----------------------------------------------------------------------------
// etgn_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module etgn_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire etgn_pkg::command_type push_cmd,
   output logic                       full,
   input  wire logic                  pop,
   output etgn_pkg::queue_head_type   head
);

   etgn_pkg::command_type                 mem_ff [etgn_pkg::QUEUE_DEPTH];
   logic [etgn_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [etgn_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                  do_push, do_pop;

   assign full       = (count_ff == etgn_pkg::QUEUE_CNT_W'(etgn_pkg::QUEUE_DEPTH));
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

>>> hdl/etgn_back.sv
// ----------------------------------------------------------------------------
// etgn_back
// Expands each queued command into records, one record per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module etgn_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire etgn_pkg::queue_head_type head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_record,
   output logic [9:0]                    rsp_gate_id,
   output logic [1:0]                    rsp_gate_kind,
   output logic                          rsp_source_is_gate,
   output logic [9:0]                    rsp_source_id,
   output logic                          rsp_pin,
   output logic [5:0]                    rsp_output_id,
   output logic [2:0]                    rsp_error_code,
   output logic                          rsp_last
);

   etgn_pkg::step_type step_ff, step_in, cur_step;
   logic               valid_ff, load, is_last;
   logic [1:0]         record_in, kind_in;
   logic [9:0]         gate_in, src_in;
   logic               isg_in, pin_in;
   logic [5:0]         oid_in;
   logic [2:0]         err_in;
   logic [1:0]         record_ff, kind_ff;
   logic [9:0]         gate_ff, src_ff;
   logic               isg_ff, pin_ff, last_ff;
   logic [5:0]         oid_ff;
   logic [2:0]         err_ff;

   assign load     = head.valid && (!valid_ff || !rsp_stall);
   assign cur_step = (step_ff == etgn_pkg::STEP_GATE && !head.cmd.gate_en) ?
                     etgn_pkg::STEP_TAIL : step_ff;
   assign is_last  = (cur_step == etgn_pkg::STEP_TAIL) ||
                     (cur_step == etgn_pkg::STEP_PIN_B && head.cmd.tail == etgn_pkg::TAIL_NONE);
   assign pop      = load && is_last;

   // next step
   always_comb begin
      step_in = step_ff;
      if (load) begin
         case (cur_step)
            etgn_pkg::STEP_GATE:  step_in = etgn_pkg::STEP_PIN_A;
            etgn_pkg::STEP_PIN_A: step_in = etgn_pkg::STEP_PIN_B;
            etgn_pkg::STEP_PIN_B: step_in = is_last ? etgn_pkg::STEP_GATE : etgn_pkg::STEP_TAIL;
            default:              step_in = etgn_pkg::STEP_GATE;
         endcase
      end
   end

   // record fields for the current step
   always_comb begin
      record_in = etgn_pkg::REC_GATE;
      gate_in   = '0;
      kind_in   = '0;
      isg_in    = 1'b0;
      src_in    = '0;
      pin_in    = 1'b0;
      oid_in    = '0;
      err_in    = '0;
      case (cur_step)
         etgn_pkg::STEP_GATE: begin
            gate_in = head.cmd.gate_id;
            kind_in = head.cmd.gate_kind;
         end
         etgn_pkg::STEP_PIN_A: begin
            record_in = etgn_pkg::REC_PIN;
            gate_in   = head.cmd.gate_id;
            isg_in    = head.cmd.pin_a.is_gate;
            src_in    = head.cmd.pin_a.id;
         end
         etgn_pkg::STEP_PIN_B: begin
            record_in = etgn_pkg::REC_PIN;
            gate_in   = head.cmd.gate_id;
            isg_in    = head.cmd.pin_b.is_gate;
            src_in    = head.cmd.pin_b.id;
            pin_in    = 1'b1;
         end
         default: begin
            if (head.cmd.tail == etgn_pkg::TAIL_DRIVE) begin
               record_in = etgn_pkg::REC_DRIVE;
               gate_in   = head.cmd.drive_gate;
               oid_in    = head.cmd.output_id;
            end else begin
               record_in = etgn_pkg::REC_ERROR;
               err_in    = head.cmd.error_code;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= etgn_pkg::STEP_GATE;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   // output register, hold while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         record_ff <= record_in;
         gate_ff   <= gate_in;
         kind_ff   <= kind_in;
         isg_ff    <= isg_in;
         src_ff    <= src_in;
         pin_ff    <= pin_in;
         oid_ff    <= oid_in;
         err_ff    <= err_in;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_record         = record_ff;
   assign rsp_gate_id        = gate_ff;
   assign rsp_gate_kind      = kind_ff;
   assign rsp_source_is_gate = isg_ff;
   assign rsp_source_id      = src_ff;
   assign rsp_pin            = pin_ff;
   assign rsp_output_id      = oid_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

>>> hdl/expression_to_gate_netlist.sv
// ----------------------------------------------------------------------------
// expression_to_gate_netlist
// Builds gate netlist records from infix or postfix boolean equation tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens arrive on the req_ channel (valid/stall); a transfer happens when
//   req_valid is high and req_stall low. Records leave on the rsp_ channel
//   one per transfer; rsp_last marks the final record caused by a token.
//   csr_write loads input_count (index 0) or output_count (index 1); write
//   only while the block is idle.
//   The front end takes one token per cycle while req_stall is low and runs
//   both stacks in that cycle; the back end drains a four-entry command
//   queue, one record per cycle while rsp_stall is low. A token's first
//   record is written into the queue and then into the output register
//   before it is valid on rsp_. A token gives up to four records (an end
//   token that applies a pending operator), so the sustained rate is set by
//   the single record output port.
//   Reset clears the stacks, the gate counter, the queue and the output.
//   When the receiver stalls, the output record holds; once the queue fills,
//   req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_to_gate_netlist (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_kind,
   input  wire logic       req_notation,
   input  wire logic [5:0] req_operand_id,
   input  wire logic [1:0] req_op_code,
   input  wire logic [5:0] req_target_id,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_record,
   output logic [9:0]      rsp_gate_id,
   output logic [1:0]      rsp_gate_kind,
   output logic            rsp_source_is_gate,
   output logic [9:0]      rsp_source_id,
   output logic            rsp_pin,
   output logic [5:0]      rsp_output_id,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last
);

   logic                     push_valid, queue_full, pop;
   etgn_pkg::command_type    push_cmd;
   etgn_pkg::queue_head_type head;

   etgn_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_notation   (req_notation),
      .req_operand_id (req_operand_id),
      .req_op_code    (req_op_code),
      .req_target_id  (req_target_id),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd)
   );

   etgn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   etgn_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record         (rsp_record),
      .rsp_gate_id        (rsp_gate_id),
      .rsp_gate_kind      (rsp_gate_kind),
      .rsp_source_is_gate (rsp_source_is_gate),
      .rsp_source_id      (rsp_source_id),
      .rsp_pin            (rsp_pin),
      .rsp_output_id      (rsp_output_id),
      .rsp_error_code     (rsp_error_code),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

>>> hdl/etgn_checker.sv
// ----------------------------------------------------------------------------
// etgn_checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module etgn_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_record,
   input wire logic [9:0] rsp_gate_id,
   input wire logic       rsp_pin,
   input wire logic       rsp_last
);

   // a stalled record holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record) && $stable(rsp_gate_id))
      else $error("stalled record changed");

   // error and drive records close their token
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record == etgn_pkg::REC_ERROR || rsp_record == etgn_pkg::REC_DRIVE)
      |-> rsp_last)
      else $error("terminal record without last");

   // a gate record is followed by its pin A connection to the same gate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_record == etgn_pkg::REC_GATE |->
      !rsp_last ##1 (!rsp_valid || (rsp_record == etgn_pkg::REC_PIN && !rsp_pin &&
                                    rsp_gate_id == $past(rsp_gate_id))))
      else $error("gate record not followed by pin A");

   // output is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record valid after reset");

endmodule

bind expression_to_gate_netlist etgn_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_record (rsp_record),
   .rsp_gate_id(rsp_gate_id),
   .rsp_pin    (rsp_pin),
   .rsp_last   (rsp_last)
);

`default_nettype wire

>>> test/expression_to_gate_netlist_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_to_gate_netlist_tb
// Self-checking bench for the equation to gate netlist block. A queue of
// token items feeds a clocked driver. A behavioral copy of the shunting-yard
// stacks and the gate counter predicts every record, and a clocked monitor
// compares each record transfer field by field. Several counter settings and
// idle/stall mixes are run.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_to_gate_netlist_tb;

   typedef struct packed {
      logic [2:0] kind;
      logic       notation;
      logic [5:0] operand_id;
      logic [1:0] op_code;
      logic [5:0] target_id;
   } token_type;

   typedef struct packed {
      logic [1:0] record;
      logic [9:0] gate_id;
      logic [1:0] gate_kind;
      logic       source_is_gate;
      logic [9:0] source_id;
      logic       pin;
      logic [5:0] output_id;
      logic [2:0] error_code;
      logic       last;
   } netrec_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic       csr_index = etgn_pkg::CSR_INPUT_COUNT;
   logic [6:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_kind = '0;
   logic       req_notation = 1'b0;
   logic [5:0] req_operand_id = '0;
   logic [1:0] req_op_code = '0;
   logic [5:0] req_target_id = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_record;
   logic [9:0] rsp_gate_id;
   logic [1:0] rsp_gate_kind;
   logic       rsp_source_is_gate;
   logic [9:0] rsp_source_id;
   logic       rsp_pin;
   logic [5:0] rsp_output_id;
   logic [2:0] rsp_error_code;
   logic       rsp_last;

   expression_to_gate_netlist u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_notation(req_notation), .req_operand_id(req_operand_id),
      .req_op_code(req_op_code), .req_target_id(req_target_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_record(rsp_record),
      .rsp_gate_id(rsp_gate_id), .rsp_gate_kind(rsp_gate_kind),
      .rsp_source_is_gate(rsp_source_is_gate), .rsp_source_id(rsp_source_id),
      .rsp_pin(rsp_pin), .rsp_output_id(rsp_output_id),
      .rsp_error_code(rsp_error_code), .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   token_type  token_q[$];
   netrec_type record_q[$];
   netrec_type step_recs[$];
   int         mismatches = 0;
   int         sender_idle = 0;
   int         recv_stall = 0;
   int         tokens_added = 0;

   // netlist builder state
   logic [1:0]  op_stk[etgn_pkg::OP_STACK_DEPTH];
   logic [10:0] opd_stk[etgn_pkg::EVAL_STACK_DEPTH];
   int          op_dep = 0;
   int          opd_dep = 0;
   int          next_gate = 0;
   bit          discarding = 0;
   int          in_cnt = 0;
   int          out_cnt = 0;
   int          fault;

   task automatic emit(input logic [1:0] rec, input logic [9:0] gate, input logic [1:0] gk,
                       input logic isg, input logic [9:0] src, input logic pin,
                       input logic [5:0] oid, input logic [2:0] err);
      netrec_type r;
      r = '{rec, gate, gk, isg, src, pin, oid, err, 1'b0};
      step_recs.insert(step_recs.size(), r);
   endtask

   task automatic build_gate(input logic [1:0] op);
      logic [10:0] a, b;
      if (opd_dep < 2) begin
         fault = int'(etgn_pkg::ERR_TOO_FEW);
      end else if (next_gate >= etgn_pkg::MAX_GATES) begin
         fault = int'(etgn_pkg::ERR_OVERFLOW);
      end else begin
         a = opd_stk[opd_dep-1];
         b = opd_stk[opd_dep-2];
         opd_dep -= 2;
         emit(etgn_pkg::REC_GATE, next_gate[9:0], op, 1'b0, 10'd0, 1'b0, 6'd0, 3'd0);
         emit(etgn_pkg::REC_PIN, next_gate[9:0], 2'd0, a[10], a[9:0], 1'b0, 6'd0, 3'd0);
         emit(etgn_pkg::REC_PIN, next_gate[9:0], 2'd0, b[10], b[9:0], 1'b1, 6'd0, 3'd0);
         opd_stk[opd_dep] = {1'b1, next_gate[9:0]};
         opd_dep++;
         next_gate++;
      end
   endtask

   // advance the builder by one token and queue the records it causes
   task automatic predict_records(input token_type t);
      logic [1:0] opc, top;
      step_recs.delete();
      fault = -1;
      opc = (t.op_code > etgn_pkg::OPC_OR) ? etgn_pkg::OPC_OR : t.op_code;
      if (discarding) begin
         if (t.kind == etgn_pkg::KIND_END) begin
            op_dep = 0; opd_dep = 0; discarding = 0;
         end
         return;
      end
      case (t.kind)
         etgn_pkg::KIND_OPERAND: begin
            if (!(t.operand_id < in_cnt && t.operand_id < etgn_pkg::MAX_SIGNALS))
               fault = int'(etgn_pkg::ERR_BAD_OPERAND);
            else if (opd_dep >= etgn_pkg::EVAL_STACK_DEPTH)
               fault = int'(etgn_pkg::ERR_OVERFLOW);
            else begin
               opd_stk[opd_dep] = {5'd0, t.operand_id};
               opd_dep++;
            end
         end
         etgn_pkg::KIND_OPERATOR: begin
            if (t.notation) begin
               build_gate(opc);
            end else if (op_dep > 0 && op_stk[op_dep-1] != etgn_pkg::OPC_PAREN) begin
               build_gate(op_stk[op_dep-1]);
               if (fault < 0) op_stk[op_dep-1] = opc;
            end else if (op_dep >= etgn_pkg::OP_STACK_DEPTH) begin
               fault = int'(etgn_pkg::ERR_OVERFLOW);
            end else begin
               op_stk[op_dep] = opc;
               op_dep++;
            end
         end
         etgn_pkg::KIND_LPAREN: begin
            if (t.notation) fault = int'(etgn_pkg::ERR_BAD_OPERAND);
            else if (op_dep >= etgn_pkg::OP_STACK_DEPTH) fault = int'(etgn_pkg::ERR_OVERFLOW);
            else begin
               op_stk[op_dep] = etgn_pkg::OPC_PAREN;
               op_dep++;
            end
         end
         etgn_pkg::KIND_RPAREN: begin
            if (t.notation) fault = int'(etgn_pkg::ERR_BAD_OPERAND);
            else if (op_dep == 0) fault = int'(etgn_pkg::ERR_UNMATCHED);
            else begin
               top = op_stk[op_dep-1];
               if (top == etgn_pkg::OPC_PAREN) op_dep--;
               else if (op_dep >= 2 && op_stk[op_dep-2] == etgn_pkg::OPC_PAREN) begin
                  op_dep -= 2;
                  build_gate(top);
               end else fault = int'(etgn_pkg::ERR_UNMATCHED);
            end
         end
         etgn_pkg::KIND_END: begin
            if (t.target_id >= out_cnt) fault = int'(etgn_pkg::ERR_BAD_TARGET);
            else begin
               for (int i = 0; i < op_dep; i++)
                  if (op_stk[i] == etgn_pkg::OPC_PAREN) fault = int'(etgn_pkg::ERR_OPEN_PAREN);
               if (fault < 0 && op_dep > 0) begin
                  top = op_stk[op_dep-1];
                  op_dep = 0;
                  build_gate(top);
               end
               if (fault < 0) begin
                  if (opd_dep != 1) fault = int'(etgn_pkg::ERR_COUNT);
                  else if (!opd_stk[0][10]) fault = int'(etgn_pkg::ERR_IS_INPUT);
                  else emit(etgn_pkg::REC_DRIVE, opd_stk[0][9:0], 2'd0, 1'b0, 10'd0, 1'b0,
                            t.target_id, 3'd0);
               end
            end
         end
         default: ;
      endcase
      if (t.kind == etgn_pkg::KIND_END) begin
         op_dep = 0; opd_dep = 0;
      end
      if (fault >= 0) begin
         emit(etgn_pkg::REC_ERROR, 10'd0, 2'd0, 1'b0, 10'd0, 1'b0, 6'd0, fault[2:0]);
         op_dep = 0; opd_dep = 0;
         discarding = (t.kind != etgn_pkg::KIND_END);
      end
      if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
      foreach (step_recs[i]) record_q.insert(record_q.size(), step_recs[i]);
   endtask

   // driver: predict on each accepted transfer, then present the next token
   token_type cur;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_records(cur);
         if (!req_valid || !req_stall) begin
            if (token_q.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
               cur = token_q.pop_front();
               req_valid      <= 1'b1;
               req_kind       <= cur.kind;
               req_notation   <= cur.notation;
               req_operand_id <= cur.operand_id;
               req_op_code    <= cur.op_code;
               req_target_id  <= cur.target_id;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // monitor: check each record transfer against the oldest prediction
   always @(posedge clock) begin
      netrec_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (record_q.size() == 0) begin
            report("unexpected record", rsp_record, -1);
         end else begin
            e = record_q.pop_front();
            if (rsp_record != e.record) report("record", rsp_record, e.record);
            if (rsp_gate_id != e.gate_id) report("gate_id", rsp_gate_id, e.gate_id);
            if (rsp_gate_kind != e.gate_kind)
               report("gate_kind", rsp_gate_kind, e.gate_kind);
            if (rsp_source_is_gate != e.source_is_gate)
               report("source_is_gate", rsp_source_is_gate, e.source_is_gate);
            if (rsp_source_id != e.source_id)
               report("source_id", rsp_source_id, e.source_id);
            if (rsp_pin != e.pin) report("pin", rsp_pin, e.pin);
            if (rsp_output_id != e.output_id)
               report("output_id", rsp_output_id, e.output_id);
            if (rsp_error_code != e.error_code)
               report("error_code", rsp_error_code, e.error_code);
            if (rsp_last != e.last) report("last", rsp_last, e.last);
         end
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall);
   end

   // stimulus helpers
   task automatic add(input logic [2:0] k, input logic nt, input logic [5:0] id,
                      input logic [1:0] op, input logic [5:0] tg);
      token_type t;
      t = '{k, nt, id, op, tg};
      token_q.insert(token_q.size(), t);
      tokens_added++;
   endtask

   function automatic logic [5:0] pick_operand();
      if (in_cnt > 0 && $urandom_range(0, 9) != 0)
         return 6'($urandom_range(0, (in_cnt > 64 ? 64 : in_cnt) - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   function automatic logic [5:0] pick_target();
      if (out_cnt > 0 && $urandom_range(0, 9) != 0)
         return 6'($urandom_range(0, (out_cnt > 64 ? 64 : out_cnt) - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic add_operand(input logic nt);
      add(etgn_pkg::KIND_OPERAND, nt, pick_operand(), 2'($urandom), 6'($urandom));
   endtask

   task automatic add_op(input logic nt);
      add(etgn_pkg::KIND_OPERATOR, nt, 6'($urandom), 2'($urandom_range(0, 3)),
          6'($urandom));
   endtask

   task automatic add_end(input logic nt);
      add(etgn_pkg::KIND_END, nt, 6'($urandom), 2'($urandom), pick_target());
   endtask

   task automatic gen_infix(input int lvl);
      bit paren;
      if (lvl > 3 || $urandom_range(0, 2) == 0) begin
         add_operand(1'b0);
      end else begin
         paren = 1'($urandom_range(0, 1));
         if (paren) add(etgn_pkg::KIND_LPAREN, 1'b0, 6'($urandom), 2'($urandom), 6'($urandom));
         gen_infix(lvl + 1);
         add_op(1'b0);
         gen_infix(lvl + 1);
         if (paren) add(etgn_pkg::KIND_RPAREN, 1'b0, 6'($urandom), 2'($urandom), 6'($urandom));
      end
   endtask

   task automatic gen_postfix();
      int left, depth;
      left = $urandom_range(1, 7);
      depth = 0;
      while (left > 0 || depth > 1) begin
         if (left > 0 && (depth < 2 || $urandom_range(0, 1))) begin
            add_operand(1'b1); left--; depth++;
         end else begin
            add_op(1'b1); depth--;
         end
      end
   endtask

   // mostly well-formed equations, with noise and broken ones mixed in
   task automatic gen_equations(input int count);
      int stop, r;
      logic [2:0] k;
      stop = tokens_added + count;
      while (tokens_added < stop) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            gen_infix(0); add_end(1'b0);
         end else if (r < 80) begin
            gen_postfix(); add_end(1'b1);
         end else if (r < 90) begin
            repeat ($urandom_range(1, 5)) begin
               k = 3'($urandom_range(0, 7));
               add(k, 1'($urandom), 6'($urandom), 2'($urandom), 6'($urandom));
            end
            add_end(1'($urandom));
         end else begin
            if (r[0]) gen_infix(0); else gen_postfix();
            add(3'($urandom_range(0, 3)), 1'($urandom), 6'($urandom), 2'($urandom),
                6'($urandom));
            add_end(r[0] ? 1'b0 : 1'b1);
         end
      end
   endtask

   task automatic drain();
      while (!(token_q.size() == 0 && !req_valid && record_q.size() == 0))
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[6:0];
      if (idx == etgn_pkg::CSR_INPUT_COUNT) in_cnt = value;
      else out_cnt = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_counts(input int ni, input int no);
      drain();
      write_csr(etgn_pkg::CSR_INPUT_COUNT, ni);
      write_csr(etgn_pkg::CSR_OUTPUT_COUNT, no);
   endtask

   task automatic directed_tokens();
      // extremes of operand and target, every operator, op code three
      add(etgn_pkg::KIND_OPERAND, 0, 0, 0, 0); add(etgn_pkg::KIND_OPERATOR, 0, 0, etgn_pkg::OPC_AND, 0);
      add(etgn_pkg::KIND_OPERAND, 0, 63, 0, 0); add(etgn_pkg::KIND_OPERATOR, 0, 0, etgn_pkg::OPC_XOR, 0);
      add(etgn_pkg::KIND_OPERAND, 0, 5, 0, 0); add(etgn_pkg::KIND_OPERATOR, 0, 0, 2'd3, 0);
      add(etgn_pkg::KIND_LPAREN, 0, 0, 0, 0); add(etgn_pkg::KIND_OPERAND, 0, 1, 0, 0);
      add(etgn_pkg::KIND_OPERATOR, 0, 0, etgn_pkg::OPC_OR, 0); add(etgn_pkg::KIND_OPERAND, 0, 2, 0, 0);
      add(etgn_pkg::KIND_RPAREN, 0, 0, 0, 0); add(etgn_pkg::KIND_END, 0, 0, 0, 63);
      // paren in postfix, unmatched right paren, open paren at end
      add(etgn_pkg::KIND_LPAREN, 1, 0, 0, 0); add(etgn_pkg::KIND_END, 1, 0, 0, 0);
      add(etgn_pkg::KIND_RPAREN, 0, 0, 0, 0); add(etgn_pkg::KIND_END, 0, 0, 0, 0);
      add(etgn_pkg::KIND_LPAREN, 0, 0, 0, 0); add(etgn_pkg::KIND_OPERAND, 0, 3, 0, 0);
      add(etgn_pkg::KIND_END, 0, 0, 0, 1);
      // unused kinds, count not one, result is input, empty equation, too few
      add(3'd5, 0, 63, 3, 63); add(3'd7, 1, 0, 0, 0);
      add(etgn_pkg::KIND_OPERAND, 1, 4, 0, 0); add(etgn_pkg::KIND_OPERAND, 1, 4, 0, 0);
      add(etgn_pkg::KIND_END, 1, 0, 0, 2);
      add(etgn_pkg::KIND_OPERAND, 1, 4, 0, 0); add(etgn_pkg::KIND_END, 1, 0, 0, 2);
      add(etgn_pkg::KIND_END, 0, 0, 0, 63);
      add(etgn_pkg::KIND_OPERAND, 1, 4, 0, 0); add(etgn_pkg::KIND_OPERATOR, 1, 0, etgn_pkg::OPC_AND, 0);
      add(etgn_pkg::KIND_OPERAND, 1, 4, 0, 0); add(etgn_pkg::KIND_END, 1, 0, 0, 0);
      // both stacks overflow
      repeat (etgn_pkg::EVAL_STACK_DEPTH + 1) add(etgn_pkg::KIND_OPERAND, 1, 6, 0, 0);
      add(etgn_pkg::KIND_END, 1, 0, 0, 0);
      repeat (etgn_pkg::OP_STACK_DEPTH + 1) add(etgn_pkg::KIND_LPAREN, 0, 0, 0, 0);
      add(etgn_pkg::KIND_END, 0, 0, 0, 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no idling
      set_counts(64, 64);
      directed_tokens();
      gen_equations(35);

      // everything rejected, then random counts with sender idling
      set_counts(0, 0);
      gen_equations(8);
      set_counts($urandom_range(1, 63), $urandom_range(1, 63));
      sender_idle = 56;
      gen_equations(40);

      // receiver stalling
      set_counts(64, $urandom_range(1, 64));
      sender_idle = 0; recv_stall = 56;
      gen_equations(40);

      // both sides idle
      set_counts($urandom_range(1, 64), 64);
      sender_idle = 38; recv_stall = 38;
      gen_equations(40);

      drain();
      if (mismatches == 0 && record_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hold-off against a hung handshake
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
